>>> hdl/acm_pkg.sv
// shared types and constants for the apogee detector and canard mapper
// no dependencies; used by every module in hdl/
`default_nettype none

package acm_pkg;

  // field widths
  localparam int ALT_W    = 23;
  localparam int GND_W    = 21;
  localparam int HGT_W    = 17;
  localparam int BAT_W    = 12;
  localparam int RATE_W   = 16;
  localparam int REL_W    = 23;
  localparam int PEAK_W   = 22;
  localparam int DEG_W    = 7;
  // width of the raw altitude difference before saturation
  localparam int DIFF_W   = 25;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  // register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GROUND_ALT  = 2'd0,
    REG_ARM_HEIGHT  = 2'd1,
    REG_DESCENT_MRG = 2'd2,
    REG_BATTERY_LOW = 2'd3
  } cfg_reg_t;

  // reset values of the config registers
  localparam logic signed [GND_W-1:0] GROUND_ALT_RST  = 21'sd0;
  localparam logic [HGT_W-1:0]        ARM_HEIGHT_RST  = 17'd200;
  localparam logic [HGT_W-1:0]        DESCENT_MRG_RST = 17'd50;
  localparam logic [BAT_W-1:0]        BATTERY_LOW_RST = 12'd1448;

  // saturation bounds of the relative altitude
  localparam logic signed [DIFF_W-1:0] REL_MAX = 25'sd4194303;
  localparam logic signed [DIFF_W-1:0] REL_MIN = -25'sd4194304;

  // canard map: rate -15000..15000 onto 70..110 degrees
  localparam logic signed [RATE_W:0] MAP_OFFSET = 17'sd15000;
  localparam logic signed [RATE_W:0] MAP_SPAN   = 17'sd30000;
  // 40/30000 == 1/750, done as multiply by ceil(2^24/750) and shift
  localparam logic [14:0]           MAP_RECIP  = 15'd22370;
  localparam int                    MAP_SHIFT  = 24;
  localparam logic [DEG_W-1:0]      ANG_LO     = 7'd70;
  localparam logic [DEG_W-1:0]      ANG_HI     = 7'd110;
  localparam logic [DEG_W-1:0]      ANG_MID    = 7'd90;

  // flight status handed from the state tracker to the top level
  typedef struct packed {
    logic fire_pulse;
    logic deployed;
    logic armed;
  } flight_status_t;

endpackage

`default_nettype wire

>>> hdl/acm_canard_map.sv
// maps one gyro rate onto a clamped canard angle
// depends on acm_pkg
`default_nettype none

module acm_canard_map (
  input  wire logic signed [acm_pkg::RATE_W-1:0] rate,
  output logic             [acm_pkg::DEG_W-1:0]  deg
);

  logic signed [acm_pkg::RATE_W:0] shifted;
  logic        [29:0]              prod;
  logic        [5:0]               quot;

  assign shifted = {rate[acm_pkg::RATE_W-1], rate} + acm_pkg::MAP_OFFSET;
  assign prod    = 30'(shifted[14:0]) * 30'(acm_pkg::MAP_RECIP);
  assign quot    = 6'(prod >> acm_pkg::MAP_SHIFT);

  always_comb begin
    priority if (shifted[acm_pkg::RATE_W]) begin
      // below the low end, truncation still lands on the low stop
      deg = acm_pkg::ANG_LO;
    end else if (shifted >= acm_pkg::MAP_SPAN) begin
      deg = acm_pkg::ANG_HI;
    end else begin
      deg = acm_pkg::ANG_LO + {1'b0, quot};
    end
  end

endmodule

`default_nettype wire

>>> hdl/acm_flight_state.sv
// relative altitude, peak tracking and one-shot deployment decision
// holds the peak and fired state; depends on acm_pkg
`default_nettype none

module acm_flight_state (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                step,
  input  wire logic signed [acm_pkg::ALT_W-1:0]    altitude_cm,
  input  wire logic signed [acm_pkg::GND_W-1:0]    ground_alt_cm,
  input  wire logic        [acm_pkg::HGT_W-1:0]    arm_height_cm,
  input  wire logic        [acm_pkg::HGT_W-1:0]    descent_margin_cm,
  output logic signed      [acm_pkg::REL_W-1:0]    relative_alt_cm,
  output logic             [acm_pkg::PEAK_W-1:0]   peak_alt_cm,
  output logic                                     fired_before,
  output acm_pkg::flight_status_t                  status
);

  logic [acm_pkg::PEAK_W-1:0] peak_r, peak_nxt;
  logic                       fired_r, fired_nxt;

  logic signed [acm_pkg::DIFF_W-1:0] diff;
  logic signed [acm_pkg::DIFF_W-1:0] rel_sat;
  logic signed [acm_pkg::DIFF_W-1:0] peak_ext;
  logic signed [acm_pkg::DIFF_W-1:0] drop;
  logic                              fire;

  assign diff = acm_pkg::DIFF_W'(altitude_cm) - acm_pkg::DIFF_W'(ground_alt_cm);

  always_comb begin
    priority if (diff > acm_pkg::REL_MAX) begin
      rel_sat = acm_pkg::REL_MAX;
    end else if (diff < acm_pkg::REL_MIN) begin
      rel_sat = acm_pkg::REL_MIN;
    end else begin
      rel_sat = diff;
    end
  end

  assign peak_nxt = (rel_sat > $signed({3'b000, peak_r})) ?
                    rel_sat[acm_pkg::PEAK_W-1:0] : peak_r;
  assign peak_ext = $signed({3'b000, peak_nxt});
  assign drop     = peak_ext - rel_sat;

  assign fire = !fired_r
             && (peak_nxt > acm_pkg::PEAK_W'(arm_height_cm))
             && (drop > $signed({8'd0, descent_margin_cm}));

  assign fired_nxt = fired_r | fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r  <= '0;
      fired_r <= 1'b0;
    end else if (step) begin
      peak_r  <= peak_nxt;
      fired_r <= fired_nxt;
    end
  end

  assign relative_alt_cm   = rel_sat[acm_pkg::REL_W-1:0];
  assign peak_alt_cm       = peak_nxt;
  assign fired_before      = fired_r;
  assign status.fire_pulse = fire;
  assign status.deployed   = fired_nxt;
  assign status.armed      = !fired_nxt;

endmodule

`default_nettype wire

>>> hdl/apogee_deploy_and_canard_mapper.sv
// top level: input beat register, flight state and canard maps, result register
// depends on acm_pkg, acm_flight_state, acm_canard_map
`default_nettype none

//  channel  ports            direction  payload
//  in       in_t{valid,ready,data}  slave   altitude, two gyro rates, battery count
//  out      out_t{valid,ready,data} master  altitudes, canard angles, status flags
//  cfg      cfg_we/index/wdata      write   ground, arm height, margin, battery limit
//
//  one beat per cycle sustained while out_tready stays high; a beat passes through the
//  input register and then the result register before it appears on out
//  the input register advances whenever the result register is empty or taken,
//  so in_tready follows out_tready combinationally
//  peak and fired state update as a beat moves into the result register, so
//  stalls on either side never replay or drop a beat
//  synchronous active-low reset clears valids, state and config registers

module apogee_deploy_and_canard_mapper (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // altitude_cm[22:0], rate_x[38:23], rate_y[54:39], battery_raw[66:55], zero fill
  input  wire logic [acm_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // relative_alt_cm[22:0], peak_alt_cm[44:23], canard_one_deg[51:45],
  // canard_two_deg[58:52], fire_pulse[59], deployed[60], battery_low[61],
  // error_lamp[62], armed_lamp[63]
  output logic      [acm_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [acm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [acm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // config registers
  logic signed [acm_pkg::GND_W-1:0] ground_r;
  logic        [acm_pkg::HGT_W-1:0] arm_r;
  logic        [acm_pkg::HGT_W-1:0] margin_r;
  logic        [acm_pkg::BAT_W-1:0] bat_low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ground_r  <= acm_pkg::GROUND_ALT_RST;
      arm_r     <= acm_pkg::ARM_HEIGHT_RST;
      margin_r  <= acm_pkg::DESCENT_MRG_RST;
      bat_low_r <= acm_pkg::BATTERY_LOW_RST;
    end else if (cfg_we) begin
      unique case (acm_pkg::cfg_reg_t'(cfg_index))
        acm_pkg::REG_GROUND_ALT:  ground_r  <= $signed(cfg_wdata);
        acm_pkg::REG_ARM_HEIGHT:  arm_r     <= cfg_wdata[acm_pkg::HGT_W-1:0];
        acm_pkg::REG_DESCENT_MRG: margin_r  <= cfg_wdata[acm_pkg::HGT_W-1:0];
        acm_pkg::REG_BATTERY_LOW: bat_low_r <= cfg_wdata[acm_pkg::BAT_W-1:0];
        default: ;
      endcase
    end
  end

  // input beat register
  logic                              s1_valid_r;
  logic signed [acm_pkg::ALT_W-1:0]  s1_alt_r;
  logic signed [acm_pkg::RATE_W-1:0] s1_rx_r;
  logic signed [acm_pkg::RATE_W-1:0] s1_ry_r;
  logic        [acm_pkg::BAT_W-1:0]  s1_bat_r;
  logic                              s1_adv;
  logic                              in_take;

  assign s1_adv    = s1_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_alt_r <= $signed(in_tdata[22:0]);
      s1_rx_r  <= $signed(in_tdata[38:23]);
      s1_ry_r  <= $signed(in_tdata[54:39]);
      s1_bat_r <= in_tdata[66:55];
    end
  end

  // per-beat logic
  logic signed [acm_pkg::REL_W-1:0]  rel;
  logic        [acm_pkg::PEAK_W-1:0] peak;
  logic                              fired_before;
  acm_pkg::flight_status_t           status;
  logic        [acm_pkg::DEG_W-1:0]  map_one, map_two;
  logic        [acm_pkg::DEG_W-1:0]  deg_one, deg_two;
  logic                              bat_low;

  acm_flight_state u_flight (
    .clk               (clk),
    .rst_n             (rst_n),
    .step              (s1_adv),
    .altitude_cm       (s1_alt_r),
    .ground_alt_cm     (ground_r),
    .arm_height_cm     (arm_r),
    .descent_margin_cm (margin_r),
    .relative_alt_cm   (rel),
    .peak_alt_cm       (peak),
    .fired_before      (fired_before),
    .status            (status)
  );

  acm_canard_map u_map_one (.rate(s1_rx_r), .deg(map_one));
  acm_canard_map u_map_two (.rate(s1_ry_r), .deg(map_two));

  // canards still steer on the firing beat, parked from the next one on
  assign deg_one = fired_before ? acm_pkg::ANG_MID : map_one;
  assign deg_two = fired_before ? acm_pkg::ANG_MID : map_two;
  assign bat_low = s1_bat_r < bat_low_r;

  // result register
  logic                              out_valid_r, out_valid_nxt;
  logic [acm_pkg::OUT_DATA_W-1:0]    out_data_r, out_data_nxt;

  assign out_valid_nxt = s1_adv || (out_valid_r && !out_tready);
  assign out_data_nxt  = {status.armed,
                          bat_low | status.deployed,
                          bat_low,
                          status.deployed,
                          status.fire_pulse,
                          deg_two,
                          deg_one,
                          peak,
                          rel};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> dv/apogee_deploy_and_canard_mapper_tb.sv
`timescale 1ns / 1ps
// self-checking bench for apogee_deploy_and_canard_mapper: a directed flight profile
// plus random sensor beats, scored against an in-bench model of the detector
// depends on acm_pkg and the rtl under hdl/

module apogee_deploy_and_canard_mapper_tb;
  import acm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ALT_MIN = -(1 << (ALT_W - 1));
  localparam int ALT_MAX = (1 << (ALT_W - 1)) - 1;
  localparam int GND_MIN = -(1 << (GND_W - 1));
  localparam int GND_MAX = (1 << (GND_W - 1)) - 1;
  localparam int HGT_MAX = (1 << HGT_W) - 1;
  localparam int BAT_MAX = (1 << BAT_W) - 1;
  // relative altitude ceiling kept until the flight phase, so nothing fires early
  localparam int PRE_CAP = 200;

  // one input beat, altitude in the lowest bits
  typedef struct packed {
    logic [BAT_W-1:0]         battery;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [ALT_W-1:0]  alt;
  } sample_t;

  // one result beat, relative altitude in the lowest bits
  typedef struct packed {
    logic                    armed;
    logic                    error_lamp;
    logic                    bat_low;
    logic                    deployed;
    logic                    fire;
    logic [DEG_W-1:0]        canard_two;
    logic [DEG_W-1:0]        canard_one;
    logic [PEAK_W-1:0]       peak;
    logic signed [REL_W-1:0] rel;
  } result_t;

  // flight model plus the queue of results still owed by the block
  class flight_scoreboard;
    result_t                 expected_q[$];
    logic signed [GND_W-1:0] ground;
    logic [HGT_W-1:0]        arm_height;
    logic [HGT_W-1:0]        margin;
    logic [BAT_W-1:0]        battery_limit;
    logic [PEAK_W-1:0]       peak;
    bit                      fired;
    int                      errors;
    int                      checked;

    function new();
      ground        = GROUND_ALT_RST;
      arm_height    = ARM_HEIGHT_RST;
      margin        = DESCENT_MRG_RST;
      battery_limit = BATTERY_LOW_RST;
      peak          = '0;
      fired         = 1'b0;
      errors        = 0;
      checked       = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_GROUND_ALT:  ground        = val[GND_W-1:0];
        REG_ARM_HEIGHT:  arm_height    = val[HGT_W-1:0];
        REG_DESCENT_MRG: margin        = val[HGT_W-1:0];
        REG_BATTERY_LOW: battery_limit = val[BAT_W-1:0];
        default: ;
      endcase
    endfunction

    // linear map of the gyro rate onto the servo range, truncating, then clamped
    function logic [DEG_W-1:0] canard_angle(logic signed [RATE_W-1:0] rate);
      int span;
      int deg;
      span = int'(ANG_HI) - int'(ANG_LO);
      deg  = (int'(rate) + int'(MAP_OFFSET)) * span / int'(MAP_SPAN) + int'(ANG_LO);
      if (deg < int'(ANG_LO)) deg = int'(ANG_LO);
      if (deg > int'(ANG_HI)) deg = int'(ANG_HI);
      return DEG_W'(deg);
    endfunction

    function void note_sample(sample_t s);
      result_t r;
      longint  rel;
      rel = longint'($signed(s.alt)) - longint'(ground);
      // saturate to the reported width before the peak sees it
      if (rel > longint'(REL_MAX)) rel = longint'(REL_MAX);
      if (rel < longint'(REL_MIN)) rel = longint'(REL_MIN);
      if (rel > longint'(peak)) peak = PEAK_W'(rel);
      // canards still steer on the firing beat itself
      r.canard_one = fired ? ANG_MID : canard_angle(s.rate_x);
      r.canard_two = fired ? ANG_MID : canard_angle(s.rate_y);
      r.fire = !fired && (peak > arm_height) && (longint'(peak) - rel > longint'(margin));
      if (r.fire) fired = 1'b1;
      r.rel        = REL_W'(rel);
      r.peak       = peak;
      r.deployed   = fired;
      r.bat_low    = s.battery < battery_limit;
      r.error_lamp = r.bat_low || fired;
      r.armed      = !fired;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      // keep the log short when the block is badly off
      if (errors < 100) $display("mismatch: %s", msg);
      errors++;
    endtask

    task field_check(string name, logic [REL_W-1:0] got, logic [REL_W-1:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %0h want %0h", checked, name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result beat %0h with nothing outstanding", got));
        return;
      end
      want = expected_q.pop_front();
      field_check("relative_alt_cm", got.rel, want.rel);
      field_check("peak_alt_cm", got.peak, want.peak);
      field_check("canard_one_deg", got.canard_one, want.canard_one);
      field_check("canard_two_deg", got.canard_two, want.canard_two);
      field_check("fire_pulse", got.fire, want.fire);
      field_check("deployed", got.deployed, want.deployed);
      field_check("battery_low", got.bat_low, want.bat_low);
      field_check("error_lamp", got.error_lamp, want.error_lamp);
      field_check("armed_lamp", got.armed, want.armed);
      checked++;
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // altitude_cm, rate_x, rate_y, battery_raw, zero fill
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // relative_alt_cm, peak_alt_cm, canard_one_deg, canard_two_deg, fire_pulse,
  // deployed, battery_low, error_lamp, armed_lamp
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_GROUND_ALT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // no idling on either side while set
  logic                  calm = 1'b0;
  int                    cycles = 0;
  flight_scoreboard      sb = new();

  apogee_deploy_and_canard_mapper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side stalls about 10% of the time unless calm is set
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 10);
  end

  // note accepted samples before checking, both on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_sample(sample_t'(in_tdata[$bits(sample_t)-1:0]));
      if (out_tvalid && out_tready) sb.check_result(result_t'(out_tdata));
    end
  end

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic sample_t make_sample(int alt, int rx, int ry, int bat);
    sample_t s;
    s.alt     = ALT_W'(alt);
    s.rate_x  = RATE_W'(rx);
    s.rate_y  = RATE_W'(ry);
    s.battery = BAT_W'(bat);
    return s;
  endfunction

  // mostly inside the mapped band, sometimes anywhere in the 16-bit range
  function automatic int pick_rate();
    if ($urandom_range(0, 9) < 6) return pick(-16000, 16000);
    return int'($signed(RATE_W'($urandom)));
  endfunction

  // half the time right around the low-battery threshold
  function automatic int pick_battery();
    int b;
    if ($urandom_range(0, 1) == 0) return int'(BAT_W'($urandom));
    b = int'(sb.battery_limit) + pick(-3, 3);
    if (b < 0) b = 0;
    if (b > BAT_MAX) b = BAT_MAX;
    return b;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_sample(sample_t s);
    while (!calm && $urandom_range(0, 99) < 10) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(s);
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // let every outstanding result come back before touching registers
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // leaves cfg_we high so back-to-back writes never glitch it
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  // narrow registers get random junk above their width, which must be dropped
  task automatic apply_config(int ground, int arm, int margin, int limit);
    write_reg(REG_GROUND_ALT, CFG_DATA_W'(ground));
    write_reg(REG_ARM_HEIGHT, CFG_DATA_W'({$urandom, HGT_W'(arm)}));
    write_reg(REG_DESCENT_MRG, CFG_DATA_W'({$urandom, HGT_W'(margin)}));
    write_reg(REG_BATTERY_LOW, CFG_DATA_W'({$urandom, BAT_W'(limit)}));
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // before the flight: relative altitude never above PRE_CAP, arm height at or above it
  task automatic ground_phase(int count);
    for (int i = 0; i < count; i++) begin
      int rel;
      int alt;
      case ($urandom_range(0, 9))
        7, 8:    rel = pick(ALT_MIN - GND_MAX, PRE_CAP);  // deep, may saturate low
        9:       rel = PRE_CAP - int'($urandom_range(0, 3));
        default: rel = pick(-3000, PRE_CAP);
      endcase
      alt = rel + int'(sb.ground);
      if (alt < ALT_MIN) alt = ALT_MIN;
      send_sample(make_sample(alt, pick_rate(), pick_rate(), pick_battery()));
    end
  endtask

  // after deployment anything goes
  task automatic coast_phase(int count);
    for (int i = 0; i < count; i++) begin
      send_sample(make_sample(int'($signed(ALT_W'($urandom))), int'($signed(RATE_W'($urandom))),
                              int'($signed(RATE_W'($urandom))), int'(BAT_W'($urandom))));
    end
  endtask

  initial begin
    int arm;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: rate extremes, map edges, battery threshold edges
    send_sample(make_sample(0, -32768, 32767, 0));
    send_sample(make_sample(ALT_MIN, -15000, 15000, BAT_MAX));
    send_sample(make_sample(-1, 0, -1, 1447));
    // peak equal to the arm height is not armed
    send_sample(make_sample(PRE_CAP, -15001, 15001, 1448));
    // drop past the margin while not armed
    send_sample(make_sample(100, -14999, 14999, 2048));
    send_sample(make_sample(150, -14251, -14250, 1));
    send_sample(make_sample(PRE_CAP, 14249, 14250, 4094));
    send_sample(make_sample(20, 1, -2, 1449));

    // ground at its top: difference saturates at the low end
    settle();
    apply_config(GND_MAX, HGT_MAX, HGT_MAX, BAT_MAX);
    send_sample(make_sample(ALT_MIN, 32767, -32768, BAT_MAX - 1));
    send_sample(make_sample(GND_MAX + PRE_CAP, 7, -7, BAT_MAX));

    // ground at its bottom, zero margin, battery never low
    settle();
    apply_config(GND_MIN, PRE_CAP, 0, 0);
    send_sample(make_sample(GND_MIN, 100, -100, 0));
    send_sample(make_sample(GND_MIN + PRE_CAP, -20000, 20000, 0));

    // random pre-flight phases; one of them with no idling at all
    for (int p = 0; p < 5; p++) begin
      settle();
      arm = ($urandom_range(0, 1) == 0) ? PRE_CAP : pick(PRE_CAP, HGT_MAX);
      if (p == 1) arm = HGT_MAX;
      apply_config(pick(GND_MIN, GND_MAX), arm,
                   (p == 2) ? 0 : (p == 3) ? HGT_MAX : pick(0, HGT_MAX),
                   pick(0, BAT_MAX));
      calm = (p == 2);
      ground_phase(100);
    end
    calm = 1'b0;

    // the flight: climb to the arm height, drop without firing, rise one past it,
    // drop exactly the margin, then one more to fire; canards center afterwards
    settle();
    apply_config(0, 1000, 500, BATTERY_LOW_RST);
    send_sample(make_sample(1000, 3000, -3000, 1000));
    send_sample(make_sample(400, 9000, -9000, 2000));
    send_sample(make_sample(1001, 12000, -12000, 1447));
    send_sample(make_sample(501, -500, 500, 1448));
    send_sample(make_sample(500, 14999, -14999, 100));
    send_sample(make_sample(400, 14999, -14999, 3000));
    send_sample(make_sample(30000, -32768, 32767, 0));

    // after deployment: extreme settings, saturation at the high end
    settle();
    apply_config(GND_MIN, 0, 0, BAT_MAX);
    send_sample(make_sample(ALT_MAX, 0, 0, BAT_MAX));
    send_sample(make_sample(ALT_MIN, -1, 1, BAT_MAX - 1));

    for (int p = 0; p < 2; p++) begin
      settle();
      apply_config(pick(GND_MIN, GND_MAX), pick(0, HGT_MAX), pick(0, HGT_MAX),
                   pick(0, BAT_MAX));
      coast_phase(100);
    end

    settle();
    repeat (10) @(negedge clk);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
